// ===== hw/rtl/bitmap_page_allocator_defines.svh =====
// Assertion shorthands for the page allocator checker.
`ifndef BITMAP_PAGE_ALLOCATOR_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define BPA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define BPA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/bpa_pkg.sv =====
package bpa_pkg;

	// bitmap word: one used bit per page
	localparam int WORD_W = 8;
	localparam int BIT_W = $clog2(WORD_W);

	localparam int IDX_W = 16;
	localparam int CNT_W = 17;
	localparam int LIMIT_W = 17;

	localparam int NUM_PAGES_DEF = 65536;
	localparam logic [LIMIT_W-1:0] LIMIT_RST = 17'h10000;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE = 1'b1;

	typedef struct packed {
		logic clear;	// load the run tracker for a new pass
		logic valid;	// a bitmap word is on the read data
	} scan_ctl_t;

	// bits lo..hi (inclusive) of a word
	function automatic logic [WORD_W-1:0] range_mask(input logic [BIT_W-1:0] lo,
			input logic [BIT_W-1:0] hi);
		logic [WORD_W-1:0] m;
		for (int j = 0; j < WORD_W; j++) begin
			m[j] = (BIT_W'(j) >= lo) && (BIT_W'(j) <= hi);
		end
		return m;
	endfunction

endpackage

// ===== hw/rtl/bpa_ram.sv =====
module bpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/bpa_scan.sv =====
module bpa_scan import bpa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  scan_ctl_t         ctl,
	input  logic [CNT_W-1:0]  cnt,
	input  logic [WORD_W-1:0] mask,
	input  logic [WORD_W-1:0] word,
	output logic              hit,
	output logic [BIT_W-1:0]  hit_bit
);

	// pages still missing for the run that is open at the word boundary
	logic [CNT_W-1:0]  need_q;
	logic [CNT_W-1:0]  need_nxt;
	logic [WORD_W-1:0] free_v;
	logic [WORD_W-1:0] all_v;
	logic [WORD_W-1:0] hit_v;
	logic [BIT_W:0]    run [WORD_W];
	logic [BIT_W:0]    run_acc;
	logic              all_acc;

	always_comb begin
		free_v = ~word & mask;
		run_acc = '0;
		all_acc = 1'b1;
		for (int j = 0; j < WORD_W; j++) begin
			run_acc = free_v[j] ? run_acc + 1'b1 : '0;
			all_acc = all_acc & free_v[j];
			run[j] = run_acc;
			all_v[j] = all_acc;
		end
		// a run that reaches back to bit 0 continues the run of earlier words
		for (int j = 0; j < WORD_W; j++) begin
			hit_v[j] = free_v[j] && (all_v[j] ? (need_q <= CNT_W'(j + 1))
				: (cnt <= CNT_W'(run[j])));
		end
		hit_bit = '0;
		for (int j = WORD_W - 1; j >= 0; j--) begin
			if (hit_v[j])
				hit_bit = BIT_W'(j);
		end
		need_nxt = all_v[WORD_W-1] ? need_q - CNT_W'(WORD_W)
			: cnt - CNT_W'(run[WORD_W-1]);
	end

	assign hit = ctl.valid && (|hit_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			need_q <= '0;
		end else if (ctl.clear) begin
			need_q <= cnt;
		end else if (ctl.valid && !hit) begin
			need_q <= need_nxt;
		end
	end

endmodule

// ===== hw/rtl/bitmap_page_allocator.sv =====
// Next-fit contiguous page allocator over a used-page bitmap held in a RAM of
// 8-page words. After reset the block is busy while it sets every page used;
// software then frees the usable ranges. Accept a request with start while
// busy is low. An allocate scans bitmap words from the hint to the limit,
// then from page 0 to the old hint, and then marks the words that the found
// run covers; the scan and the mark pass each read one word per cycle
// through the single RAM read port. A free reads and rewrites each word it
// covers. A zero count allocate answers in the next cycle. Each result is
// shown for exactly one cycle with done high and cannot be held off; the
// next request may be accepted in that same cycle. The limit register may
// be written at any time the block is idle; cfg_ready is always high.
module bitmap_page_allocator import bpa_pkg::*; #(
	parameter int NUM_PAGES = NUM_PAGES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               mode,
	input  logic [IDX_W-1:0]   page_index,
	input  logic [CNT_W-1:0]   page_count,
	output logic               done,
	output logic [IDX_W-1:0]   first_page,
	output logic               ok,
	output logic [CNT_W-1:0]   free_pages,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [LIMIT_W-1:0] cfg_data
);

	localparam int NUM_WORDS = (NUM_PAGES + WORD_W - 1) / WORD_W;
	localparam int AW = $clog2(NUM_WORDS);
	localparam int PW = $clog2(NUM_PAGES + 1);
	localparam int LW = (PW + 1 > CNT_W + 1) ? PW + 1 : CNT_W + 1;
	localparam logic [LW-1:0] N_L = LW'(NUM_PAGES);
	localparam logic [AW-1:0] LAST_WORD = AW'(NUM_WORDS - 1);

	typedef enum logic [8:0] {
		S_INIT  = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_PASS  = 9'b000000100,
		S_SCAN  = 9'b000001000,
		S_FOUND = 9'b000010000,
		S_FSET  = 9'b000100000,
		S_FLEN  = 9'b001000000,
		S_MOD   = 9'b010000000,
		S_CNT   = 9'b100000000
	} state_t;

	state_t state_q;

	logic [LIMIT_W-1:0] limit_q;
	logic [PW-1:0]      hint_q;
	logic [PW-1:0]      free_q;
	logic [PW-1:0]      from_q;
	logic [PW-1:0]      to_q;
	logic [PW-1:0]      endp_q;
	logic [PW-1:0]      n_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   pidx_q;
	logic               mode_q;
	logic               pass_q;
	logic               set_q;
	logic               iss_q;
	logic [AW-1:0]      rd_word_q;
	logic [AW-1:0]      first_word_q;
	logic [AW-1:0]      last_word_q;
	logic [BIT_W-1:0]   last_bit_q;
	logic [AW-1:0]      init_q;
	logic               v_s1;
	logic [AW-1:0]      addr_s1;
	logic               done_q;
	logic               ok_q;
	logic [IDX_W-1:0]   first_q;

	logic [LW-1:0]     lim_x;
	logic [PW-1:0]     lim;
	logic [PW-1:0]     pf;
	logic [PW-1:0]     pt;
	logic [PW-1:0]     pt_m1;
	logic [BIT_W-1:0]  lo_bit;
	logic [BIT_W-1:0]  hi_bit;
	logic [WORD_W-1:0] mask;
	logic [WORD_W-1:0] rdata;
	logic [WORD_W-1:0] wdata;
	logic              we;
	logic [AW-1:0]     waddr;
	logic              rd_en;
	scan_ctl_t         scan_ctl;
	logic              scan_hit;
	logic [BIT_W-1:0]  hit_bit;
	logic [PW-1:0]     hit_end;
	logic [LW-1:0]     st_x;
	logic [PW-1:0]     st;
	logic [PW-1:0]     endp_m1;
	logic [LW-1:0]     end_sum;
	logic [LW-1:0]     end_x;
	logic [LW-1:0]     pidx_x;
	logic [LW-1:0]     pidx_c;
	logic [PW-1:0]     to_m1;
	logic [LW-1:0]     dec_x;
	logic [LW-1:0]     sum_x;

	always_comb begin
		lim_x = (LW'(limit_q) < N_L) ? LW'(limit_q) : N_L;
		lim = lim_x[PW-1:0];
		if (pass_q) begin
			pf = '0;
			pt = (hint_q < lim) ? hint_q : lim;
		end else begin
			pf = hint_q;
			pt = lim;
		end
		pt_m1 = pt - 1'b1;

		lo_bit = (addr_s1 == first_word_q) ? from_q[BIT_W-1:0] : '0;
		hi_bit = (addr_s1 == last_word_q) ? last_bit_q : BIT_W'(WORD_W - 1);
		mask = range_mask(lo_bit, hi_bit);

		hit_end = PW'({addr_s1, hit_bit}) + 1'b1;
		st_x = LW'(endp_q) - LW'(cnt_q);
		st = st_x[PW-1:0];
		endp_m1 = endp_q - 1'b1;

		end_sum = LW'(pidx_q) + LW'(cnt_q);
		end_x = (end_sum < N_L) ? end_sum : N_L;
		pidx_x = LW'(pidx_q);
		pidx_c = (pidx_x < N_L) ? pidx_x : N_L;
		to_m1 = to_q - 1'b1;

		dec_x = LW'(free_q) - LW'(cnt_q);
		sum_x = LW'(free_q) + LW'(n_q);
	end

	assign scan_ctl.clear = (state_q == S_PASS);
	assign scan_ctl.valid = (state_q == S_SCAN) && v_s1;

	// stop fetching as soon as a run is found
	assign rd_en = iss_q && (((state_q == S_SCAN) && !scan_hit) || (state_q == S_MOD));

	assign we = (state_q == S_INIT) || ((state_q == S_MOD) && v_s1);
	assign waddr = (state_q == S_INIT) ? init_q : addr_s1;
	assign wdata = (state_q == S_INIT) ? '1 : (set_q ? (rdata | mask) : (rdata & ~mask));

	bpa_ram #(
		.WIDTH(WORD_W),
		.DEPTH(NUM_WORDS)
	) u_map (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (rd_en),
		.raddr(rd_word_q),
		.rdata(rdata)
	);

	bpa_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (scan_ctl),
		.cnt    (cnt_q),
		.mask   (mask),
		.word   (rdata),
		.hit    (scan_hit),
		.hit_bit(hit_bit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			limit_q <= LIMIT_RST;
			hint_q <= '0;
			free_q <= '0;
			from_q <= '0;
			to_q <= '0;
			endp_q <= '0;
			n_q <= '0;
			cnt_q <= '0;
			pidx_q <= '0;
			mode_q <= MODE_ALLOC;
			pass_q <= 1'b0;
			set_q <= 1'b0;
			iss_q <= 1'b0;
			rd_word_q <= '0;
			first_word_q <= '0;
			last_word_q <= '0;
			last_bit_q <= '0;
			init_q <= '0;
			v_s1 <= 1'b0;
			addr_s1 <= '0;
			done_q <= 1'b0;
			ok_q <= 1'b0;
			first_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid)
				limit_q <= cfg_data;

			v_s1 <= rd_en;
			addr_s1 <= rd_word_q;
			if (rd_en) begin
				if (rd_word_q == last_word_q)
					iss_q <= 1'b0;
				else
					rd_word_q <= rd_word_q + 1'b1;
			end

			case (state_q)
				S_INIT: begin
					init_q <= init_q + 1'b1;
					if (init_q == LAST_WORD)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						mode_q <= mode;
						pidx_q <= page_index;
						cnt_q <= page_count;
						pass_q <= 1'b0;
						if (mode == MODE_FREE) begin
							first_q <= '0;
							state_q <= S_FSET;
						end else if (page_count == '0) begin
							done_q <= 1'b1;
							ok_q <= 1'b0;
							first_q <= '0;
						end else begin
							state_q <= S_PASS;
						end
					end
				end
				S_PASS: begin
					if (pf >= pt) begin
						if (pass_q) begin
							done_q <= 1'b1;
							ok_q <= 1'b0;
							first_q <= '0;
							state_q <= S_IDLE;
						end else begin
							pass_q <= 1'b1;
						end
					end else begin
						from_q <= pf;
						to_q <= pt;
						first_word_q <= pf[BIT_W +: AW];
						rd_word_q <= pf[BIT_W +: AW];
						last_word_q <= pt_m1[BIT_W +: AW];
						last_bit_q <= pt_m1[BIT_W-1:0];
						iss_q <= 1'b1;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_hit) begin
						endp_q <= hit_end;
						state_q <= S_FOUND;
					end else if (v_s1 && (addr_s1 == last_word_q)) begin
						// pass exhausted; wrap once to page zero
						if (pass_q) begin
							done_q <= 1'b1;
							ok_q <= 1'b0;
							first_q <= '0;
							state_q <= S_IDLE;
						end else begin
							pass_q <= 1'b1;
							state_q <= S_PASS;
						end
					end
				end
				S_FOUND: begin
					from_q <= st;
					to_q <= endp_q;
					first_word_q <= st[BIT_W +: AW];
					rd_word_q <= st[BIT_W +: AW];
					last_word_q <= endp_m1[BIT_W +: AW];
					last_bit_q <= endp_m1[BIT_W-1:0];
					hint_q <= endp_q;
					first_q <= IDX_W'(st);
					set_q <= 1'b1;
					iss_q <= 1'b1;
					state_q <= S_MOD;
				end
				S_FSET: begin
					from_q <= pidx_c[PW-1:0];
					to_q <= end_x[PW-1:0];
					if (LW'(hint_q) > pidx_x)
						hint_q <= PW'(pidx_q);
					state_q <= S_FLEN;
				end
				S_FLEN: begin
					n_q <= to_q - from_q;
					if (to_q != from_q) begin
						first_word_q <= from_q[BIT_W +: AW];
						rd_word_q <= from_q[BIT_W +: AW];
						last_word_q <= to_m1[BIT_W +: AW];
						last_bit_q <= to_m1[BIT_W-1:0];
						set_q <= 1'b0;
						iss_q <= 1'b1;
						state_q <= S_MOD;
					end else begin
						state_q <= S_CNT;
					end
				end
				S_MOD: begin
					if (v_s1 && (addr_s1 == last_word_q))
						state_q <= S_CNT;
				end
				S_CNT: begin
					if (mode_q == MODE_FREE)
						free_q <= (sum_x > N_L) ? N_L[PW-1:0] : sum_x[PW-1:0];
					else
						free_q <= (LW'(free_q) > LW'(cnt_q)) ? dec_x[PW-1:0] : '0;
					done_q <= 1'b1;
					ok_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign first_page = first_q;
	assign ok = ok_q;
	assign free_pages = CNT_W'(free_q);
	assign cfg_ready = 1'b1;

endmodule

// ===== hw/rtl/bpa_checker.sv =====
`include "bitmap_page_allocator_defines.svh"

module bpa_checker import bpa_pkg::*; #(
	parameter int NUM_PAGES = NUM_PAGES_DEF
) (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input logic             ok,
	input logic [IDX_W-1:0] first_page,
	input logic [CNT_W-1:0] free_pages
);

	// a failed allocate never reports a page
	`BPA_ASSERT_IMP(a_fail_no_page, done && !ok, first_page == '0, "failed request with a page")

	// the free count is bounded by the store
	`BPA_ASSERT_IMP(a_free_bound, done, free_pages <= NUM_PAGES, "free count above store size")

	// an accepted request either starts work or answers at once
	`BPA_ASSERT_NXT(a_accept_moves, start && !busy, busy || done, "transfer ignored")

	// a result only follows work or a transfer
	`BPA_ASSERT_IMP(a_done_source, done, $past(busy) || $past(start), "result without request")

endmodule

bind bitmap_page_allocator bpa_checker #(
	.NUM_PAGES(NUM_PAGES)
) u_bpa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.ok        (ok),
	.first_page(first_page),
	.free_pages(free_pages)
);
